// File: rtl/wed_pkg.sv
// shared constants, types and helpers for the weighted edit distance block
package wed_pkg;

  localparam int MAX_LEN   = 64;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int STR_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int CHAR_W    = 8;
  localparam int COST_W    = 8;
  localparam int DIST_W    = 16;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INSERT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELETE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE = CFG_IDX_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_FINISH        = 2'd2
  } wed_cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_START,
    ST_CELL_READ,
    ST_CELL_CALC,
    ST_DONE
  } wed_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic init_step;
    logic row_start;
    logic row_next;
    logic cell_calc;
    logic emit;
  } wed_ctl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic init_last;
    logic cell_last;
    logic row_last;
    logic n_zero;
    logic m_zero;
    logic out_valid;
  } wed_status_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {{(DIST_W - COST_W + 1){1'b0}}, b};
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

// File: rtl/wed_ram.sv
// generic simple dual-port ram with registered read
module wed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/wed_ctrl.sv
// controller state machine: request handshake and sweep sequencing
module wed_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [wed_pkg::CMD_W-1:0]        command,
  output logic                             in_stall,
  input  wed_pkg::wed_status_t             status,
  output wed_pkg::wed_ctl_t                ctl
);
  import wed_pkg::*;

  wed_state_t state;
  wed_state_t state_next;
  logic       accept;

  // every request waits while a sweep runs; a finish request also waits while the previous result is still pending
  assign in_stall = (state != ST_IDLE) ||
                    ((command == CMD_FINISH) && status.out_valid);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_FINISH)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        if (status.init_last) begin
          state_next = status.m_zero ? ST_DONE : ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        if (status.n_zero) begin
          state_next = status.row_last ? ST_DONE : ST_ROW_START;
        end else begin
          state_next = ST_CELL_READ;
        end
      end
      ST_CELL_READ: begin
        state_next = ST_CELL_CALC;
      end
      ST_CELL_CALC: begin
        if (status.cell_last) begin
          state_next = status.row_last ? ST_DONE : ST_ROW_START;
        end else begin
          state_next = ST_CELL_READ;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.load_first  = accept && (command == CMD_APPEND_FIRST);
    ctl.load_second = accept && (command == CMD_APPEND_SECOND);
    ctl.start       = accept && (command == CMD_FINISH);
    case (state)
      ST_INIT: begin
        ctl.init_step = !status.init_last;
      end
      ST_ROW_START: begin
        ctl.row_start = 1'b1;
        ctl.row_next  = status.n_zero && !status.row_last;
      end
      ST_CELL_CALC: begin
        ctl.cell_calc = 1'b1;
        ctl.row_next  = status.cell_last && !status.row_last;
      end
      ST_DONE: begin
        ctl.emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/wed_dp.sv
// datapath: string stores, dp row store, cost registers and cell arithmetic
module wed_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wed_pkg::COST_W-1:0]        cfg_data,
  input  logic [wed_pkg::CHAR_W-1:0]        char_byte,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [wed_pkg::DIST_W-1:0]        distance,
  output logic                              too_long,
  input  wed_pkg::wed_ctl_t                 ctl,
  output wed_pkg::wed_status_t              status
);
  import wed_pkg::*;

  logic [COST_W-1:0] ins_cost;
  logic [COST_W-1:0] del_cost;
  logic [COST_W-1:0] rep_cost;

  logic [LEN_W-1:0]  first_len;
  logic [LEN_W-1:0]  second_len;
  logic              overflow;

  logic [LEN_W-1:0]  i;
  logic [LEN_W-1:0]  i_plus;
  logic [STR_AW-1:0] j;
  logic [DIST_W-1:0] left;
  logic [DIST_W-1:0] diag;
  logic [DIST_W-1:0] corner;
  logic [DIST_W-1:0] corner_next;
  logic [DIST_W-1:0] init_val;
  logic [DIST_W-1:0] cell_val;
  logic [DIST_W-1:0] cost_del;
  logic [DIST_W-1:0] cost_ins;
  logic [DIST_W-1:0] cost_rep;
  logic [DIST_W-1:0] min_a;

  logic              first_we;
  logic              second_we;
  logic [CHAR_W-1:0] first_rdata;
  logic [CHAR_W-1:0] second_rdata;
  logic              row_we;
  logic [DIST_W-1:0] row_wdata;
  logic [DIST_W-1:0] row_rdata;

  logic              out_valid_next;

  assign i_plus = i + LEN_W'(1);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ins_cost <= COST_W'(1);
      del_cost <= COST_W'(1);
      rep_cost <= COST_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INSERT:  ins_cost <= cfg_data;
        REG_DELETE:  del_cost <= cfg_data;
        REG_REPLACE: rep_cost <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // string loading, bytes past the end are dropped
  assign first_we  = ctl.load_first  && (first_len  < LEN_W'(MAX_LEN));
  assign second_we = ctl.load_second && (second_len < LEN_W'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      overflow   <= 1'b0;
    end else if (ctl.emit) begin
      first_len  <= '0;
      second_len <= '0;
      overflow   <= 1'b0;
    end else begin
      if (first_we) begin
        first_len <= first_len + LEN_W'(1);
      end
      if (second_we) begin
        second_len <= second_len + LEN_W'(1);
      end
      if ((ctl.load_first && !first_we) || (ctl.load_second && !second_we)) begin
        overflow <= 1'b1;
      end
    end
  end

  wed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_len[STR_AW-1:0]),
    .wdata (char_byte),
    .raddr (i[STR_AW-1:0]),
    .rdata (first_rdata)
  );

  wed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_len[STR_AW-1:0]),
    .wdata (char_byte),
    .raddr (j),
    .rdata (second_rdata)
  );

  // row entry 0 lives in the corner register, entries 1..n in the ram
  assign row_we    = ctl.init_step || ctl.cell_calc;
  assign row_wdata = ctl.init_step ? init_val : cell_val;

  wed_ram #(.WIDTH(DIST_W), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (i_plus),
    .wdata (row_wdata),
    .raddr (i_plus),
    .rdata (row_rdata)
  );

  // cell arithmetic: left is the new entry below, row_rdata the old one above
  assign init_val    = sat_add(left, del_cost);
  assign corner_next = sat_add(corner, ins_cost);
  assign cost_del    = sat_add(left, del_cost);
  assign cost_ins    = sat_add(row_rdata, ins_cost);
  assign cost_rep    = sat_add(diag, rep_cost);
  assign min_a       = (cost_del < cost_ins) ? cost_del : cost_ins;

  always_comb begin
    if (first_rdata == second_rdata) begin
      cell_val = diag;
    end else begin
      cell_val = (min_a < cost_rep) ? min_a : cost_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      i      <= '0;
      j      <= '0;
      left   <= '0;
      corner <= '0;
    end else begin
      if (ctl.init_step) begin
        left <= init_val;
        i    <= i_plus;
      end
      if (ctl.row_start) begin
        diag   <= corner;
        corner <= corner_next;
        left   <= corner_next;
        i      <= '0;
      end
      if (ctl.cell_calc) begin
        left <= cell_val;
        diag <= row_rdata;
        i    <= i_plus;
      end
      if (ctl.row_next) begin
        j <= j + STR_AW'(1);
      end
    end
  end

  // result register
  assign out_valid_next = ctl.emit || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      distance <= left;
      too_long <= overflow;
    end
  end

  assign status.init_last = (i == first_len);
  assign status.cell_last = (i_plus == first_len);
  assign status.row_last  = ((LEN_W'(j) + LEN_W'(1)) == second_len);
  assign status.n_zero    = (first_len == '0);
  assign status.m_zero    = (second_len == '0);
  assign status.out_valid = out_valid;

endmodule

// File: rtl/weighted_edit_distance.sv
// top level of the weighted edit distance engine
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  command, char_byte
//   out      source     out_valid/ out_stall distance, too_long
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// an append is taken when no sweep runs; after a finish is taken in_stall
// stays high through the sweep: an init pass, then for each row a row start and
// a read and an update per cell, as the row ram has one read/write port pair
// the result sits in an output register, so appends go on while it waits
// a finish request is held off until the previous result has been taken
// rst is synchronous; it clears lengths, flags and costs (to 1)
module weighted_edit_distance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wed_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wed_pkg::COST_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [wed_pkg::CMD_W-1:0]        command,
  input  logic [wed_pkg::CHAR_W-1:0]       char_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [wed_pkg::DIST_W-1:0]       distance,
  output logic                             too_long
);
  import wed_pkg::*;

  wed_ctl_t    ctl;
  wed_status_t status;

  wed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  wed_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .char_byte (char_byte),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .distance  (distance),
    .too_long  (too_long),
    .ctl       (ctl),
    .status    (status)
  );

endmodule

// File: rtl/wed_checker.sv
// port-level checks for the weighted edit distance engine, bound to the top
module wed_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [wed_pkg::CMD_W-1:0]        command,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [wed_pkg::DIST_W-1:0]       distance,
  input logic                             too_long
);
  import wed_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance) && $stable(too_long))
    else $error("result changed while stalled");

  // a finish request starts a sweep: input held off, no result yet
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_FINISH) |=> in_stall && !out_valid)
    else $error("finish request did not start a sweep");

  // a result only appears at the end of a sweep
  a_result_after_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a sweep");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind weighted_edit_distance wed_checker u_wed_checker (.*);
